### rtl/bfa_pkg.sv
// Package for the bitmap frame allocator.
// Holds the sizing constants, field widths, command and status codes.
// No dependencies.
package bfa_pkg;

    localparam int TOTAL_FRAMES    = 8192;
    localparam int RESERVED_FRAMES = 256;
    localparam int PAGE_SIZE       = 4096;

    localparam int RES_LIMIT  = (RESERVED_FRAMES < TOTAL_FRAMES) ? RESERVED_FRAMES
                                                                : TOTAL_FRAMES;
    localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);

    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int NUM_WORDS  = (TOTAL_FRAMES + WORD_W - 1) / WORD_W;
    localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int FRAME_W    = WIDX_W + BIT_W;
    localparam int COUNT_W    = $clog2(TOTAL_FRAMES + 1);
    localparam int START_WORD = (RES_LIMIT / WORD_W < NUM_WORDS) ? RES_LIMIT / WORD_W
                                                                 : NUM_WORDS - 1;

    localparam int CMD_W     = 1;
    localparam int ADDR_W    = 32;
    localparam int FADDR_W   = 25;
    localparam int STATUS_W  = 3;
    localparam int CNT_OUT_W = 14;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOMEM   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADADDR = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTUSED = 3'd4;

endpackage

### rtl/bfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the frame bitmap; no dependencies.
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/bitmap_frame_allocator.sv
// A rejected request goes straight to the result stage, a free reads and checks one bitmap
// word, and an allocate reads and checks bitmap words one by one, starting at the
// lowest word that may hold a free frame (one RAM read and one compare per word).
// One request at a time; the next is accepted once the result is staged in the
// output register. Reset (rst_n, async) loads both counts and clears the word-valid
// bits: unwritten words read as their reset pattern. Depends on bfa_pkg and bfa_ram.
module bitmap_frame_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bfa_pkg::CMD_W-1:0]     cmd,
    input  logic [bfa_pkg::ADDR_W-1:0]    address,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bfa_pkg::FADDR_W-1:0]   frame_address,
    output logic [bfa_pkg::STATUS_W-1:0]  status,
    output logic [bfa_pkg::CNT_OUT_W-1:0] free_count,
    output logic [bfa_pkg::CNT_OUT_W-1:0] used_count
);

    typedef enum logic [1:0] {S_IDLE, S_RD, S_CHK, S_FIN} state_t;

    state_t                           state_reg, state_next;
    logic [bfa_pkg::CMD_W-1:0]        cmd_reg, cmd_next;
    logic [bfa_pkg::WIDX_W-1:0]       widx_reg, widx_next;
    logic [bfa_pkg::BIT_W-1:0]        bit_reg, bit_next;
    logic [bfa_pkg::WIDX_W-1:0]       hint_reg, hint_next;
    logic [bfa_pkg::COUNT_W-1:0]      free_reg, free_next;
    logic [bfa_pkg::COUNT_W-1:0]      used_reg, used_next;
    logic [bfa_pkg::NUM_WORDS-1:0]    wvalid_reg, wvalid_next;
    logic [bfa_pkg::STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [bfa_pkg::FRAME_W-1:0]      res_frame_reg, res_frame_next;
    logic                             out_valid_reg, out_valid_next;
    logic [bfa_pkg::FADDR_W-1:0]      out_faddr_reg, out_faddr_next;
    logic [bfa_pkg::STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [bfa_pkg::CNT_OUT_W-1:0]    out_free_reg, out_free_next;
    logic [bfa_pkg::CNT_OUT_W-1:0]    out_used_reg, out_used_next;

    logic                             ram_we;
    logic [bfa_pkg::WORD_W-1:0]       ram_wdata;
    logic [bfa_pkg::WORD_W-1:0]       ram_rdata;
    logic [bfa_pkg::WORD_W-1:0]       word;
    logic [bfa_pkg::BIT_W-1:0]        zero_bit;
    logic                             any_zero;
    logic                             slot_free;
    logic [bfa_pkg::ADDR_W-1:0]       fr;
    logic [63:0]                      fa_wide;
    logic [63:0]                      free_wide;
    logic [63:0]                      used_wide;

    function automatic logic [bfa_pkg::WORD_W-1:0] reset_word(
        input logic [bfa_pkg::WIDX_W-1:0] w
    );
        logic [bfa_pkg::WORD_W-1:0] v;
        int                         f;
        v = '0;
        for (int b = 0; b < bfa_pkg::WORD_W; b++)
        begin
            f = int'(w) * bfa_pkg::WORD_W + b;
            v[b] = (f < bfa_pkg::RES_LIMIT) || (f >= bfa_pkg::TOTAL_FRAMES);
        end
        return v;
    endfunction

    bfa_ram #(
        .WIDTH (bfa_pkg::WORD_W),
        .DEPTH (1 << bfa_pkg::WIDX_W)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx_reg),
        .wdata (ram_wdata),
        .raddr (widx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        word = wvalid_reg[widx_reg] ? ram_rdata : reset_word(widx_reg);
        any_zero = ~&word;
        zero_bit = '0;
        for (int b = bfa_pkg::WORD_W - 1; b >= 0; b--)
        begin
            if (!word[b])
            begin
                zero_bit = bfa_pkg::BIT_W'(b);
            end
        end
    end

    assign fr        = address >> bfa_pkg::PAGE_SHIFT;
    assign slot_free = !out_valid_reg || out_ready;
    assign fa_wide   = 64'(res_frame_reg) << bfa_pkg::PAGE_SHIFT;
    assign free_wide = 64'(free_reg);
    assign used_wide = 64'(used_reg);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        widx_next       = widx_reg;
        bit_next        = bit_reg;
        hint_next       = hint_reg;
        free_next       = free_reg;
        used_next       = used_reg;
        wvalid_next     = wvalid_reg;
        res_status_next = res_status_reg;
        res_frame_next  = res_frame_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_faddr_next  = out_faddr_reg;
        out_status_next = out_status_reg;
        out_free_next   = out_free_reg;
        out_used_next   = out_used_reg;
        ram_we          = 1'b0;
        ram_wdata       = word;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = cmd;
                    res_frame_next  = '0;
                    res_status_next = bfa_pkg::ST_OK;
                    if (cmd == bfa_pkg::CMD_ALLOC)
                    begin
                        if (free_reg == '0)
                        begin
                            res_status_next = bfa_pkg::ST_NOMEM;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            widx_next  = hint_reg;
                            state_next = S_RD;
                        end
                    end
                    else if (address == '0 || address[bfa_pkg::PAGE_SHIFT-1:0] != '0)
                    begin
                        res_status_next = bfa_pkg::ST_BADADDR;
                        state_next      = S_FIN;
                    end
                    else if (fr < bfa_pkg::ADDR_W'(bfa_pkg::RES_LIMIT) ||
                             fr >= bfa_pkg::ADDR_W'(bfa_pkg::TOTAL_FRAMES))
                    begin
                        res_status_next = bfa_pkg::ST_RANGE;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        widx_next  = fr[bfa_pkg::BIT_W +: bfa_pkg::WIDX_W];
                        bit_next   = fr[bfa_pkg::BIT_W-1:0];
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (cmd_reg == bfa_pkg::CMD_ALLOC)
                begin
                    if (any_zero)
                    begin
                        ram_we                = 1'b1;
                        ram_wdata             = word | (bfa_pkg::WORD_W'(1) << zero_bit);
                        wvalid_next[widx_reg] = 1'b1;
                        free_next             = free_reg - bfa_pkg::COUNT_W'(1);
                        used_next             = used_reg + bfa_pkg::COUNT_W'(1);
                        res_frame_next        = {widx_reg, zero_bit};
                        res_status_next       = bfa_pkg::ST_OK;
                        hint_next             = widx_reg;
                        state_next            = S_FIN;
                    end
                    else if (widx_reg == bfa_pkg::WIDX_W'(bfa_pkg::NUM_WORDS - 1))
                    begin
                        res_status_next = bfa_pkg::ST_NOMEM;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        widx_next  = widx_reg + bfa_pkg::WIDX_W'(1);
                        state_next = S_RD;
                    end
                end
                else
                begin
                    if (!word[bit_reg])
                    begin
                        res_status_next = bfa_pkg::ST_NOTUSED;
                    end
                    else
                    begin
                        ram_we                = 1'b1;
                        ram_wdata             = word & ~(bfa_pkg::WORD_W'(1) << bit_reg);
                        wvalid_next[widx_reg] = 1'b1;
                        free_next             = free_reg + bfa_pkg::COUNT_W'(1);
                        used_next             = used_reg - bfa_pkg::COUNT_W'(1);
                        res_status_next       = bfa_pkg::ST_OK;
                        hint_next             = (widx_reg < hint_reg) ? widx_reg : hint_reg;
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_faddr_next  = fa_wide[bfa_pkg::FADDR_W-1:0];
                    out_status_next = res_status_reg;
                    out_free_next   = free_wide[bfa_pkg::CNT_OUT_W-1:0];
                    out_used_next   = used_wide[bfa_pkg::CNT_OUT_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hint_reg      <= bfa_pkg::WIDX_W'(bfa_pkg::START_WORD);
            free_reg      <= bfa_pkg::COUNT_W'(bfa_pkg::TOTAL_FRAMES - bfa_pkg::RES_LIMIT);
            used_reg      <= bfa_pkg::COUNT_W'(bfa_pkg::RES_LIMIT);
            wvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            free_reg      <= free_next;
            used_reg      <= used_next;
            wvalid_reg    <= wvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        widx_reg       <= widx_next;
        bit_reg        <= bit_next;
        res_status_reg <= res_status_next;
        res_frame_reg  <= res_frame_next;
        out_faddr_reg  <= out_faddr_next;
        out_status_reg <= out_status_next;
        out_free_reg   <= out_free_next;
        out_used_reg   <= out_used_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign frame_address = out_faddr_reg;
    assign status        = out_status_reg;
    assign free_count    = out_free_reg;
    assign used_count    = out_used_reg;

    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (bfa_pkg::COUNT_W + 1)'(free_reg) + (bfa_pkg::COUNT_W + 1)'(used_reg)
            == (bfa_pkg::COUNT_W + 1)'(bfa_pkg::TOTAL_FRAMES))
        else $error("free and used counts do not add up to the frame total");

    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && cmd_reg == bfa_pkg::CMD_ALLOC) |=>
            (used_reg == $past(used_reg) + bfa_pkg::COUNT_W'(1)))
        else $error("allocate wrote the bitmap without counting the frame");

    a_alloc_above_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && cmd_reg == bfa_pkg::CMD_ALLOC &&
         res_status_reg == bfa_pkg::ST_OK) |->
            (32'(res_frame_reg) >= 32'(bfa_pkg::RES_LIMIT)))
        else $error("allocated frame lies in the reserved region");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while the previous one is in progress");

endmodule
